[rtl/clock_date_time_setter_defines.svh]
// Assertion macros shared by the date and time setting controller.
`ifndef CLOCK_DATE_TIME_SETTER_DEFINES_SVH
`define CLOCK_DATE_TIME_SETTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define CDTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clock_date_time_setter: check failed");

// Next-cycle implication, sampled on the rising clock edge and idle in reset.
`define CDTS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clock_date_time_setter: check failed");

`endif

[rtl/cdts_pkg.sv]
// Package with the word types, codes and calendar helpers of the date and time setter.
`default_nettype none

package cdts_pkg;

  localparam int unsigned PaddrW = 3;

  localparam logic [2:0] ACT_SAMPLE = 3'd0;
  localparam logic [2:0] ACT_RAISE  = 3'd1;
  localparam logic [2:0] ACT_NEXT   = 3'd2;
  localparam logic [2:0] ACT_SWAP   = 3'd3;
  localparam logic [2:0] ACT_COMMIT = 3'd4;

  localparam logic [1:0] DSEL_DAY   = 2'd0;
  localparam logic [1:0] DSEL_MONTH = 2'd1;
  localparam logic [1:0] DSEL_YEAR  = 2'd2;
  localparam logic [1:0] DSEL_WDAY  = 2'd3;

  localparam logic [1:0] TSEL_HOUR  = 2'd0;
  localparam logic [1:0] TSEL_MIN   = 2'd1;
  localparam logic [1:0] TSEL_PM    = 2'd2;

  localparam logic [11:0] YEAR_BASE = 12'd2000;
  localparam logic [11:0] YEAR_LAST = 12'd2099;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] sample_minute_bcd;
    logic [7:0] sample_hour_bcd;
    logic [7:0] sample_date_bcd;
    logic [7:0] sample_month_bcd;
    logic [7:0] sample_weekday;
    logic [7:0] sample_year_bcd;
  } cdts_in_t;

  typedef struct packed {
    logic        editing;
    logic [2:0]  cursor_field;
    logic [4:0]  shown_day;
    logic [3:0]  shown_month;
    logic [11:0] shown_year;
    logic [2:0]  shown_weekday;
    logic [4:0]  shown_hour;
    logic [5:0]  shown_minute;
    logic        shown_pm;
    logic        commit_valid;
    logic [47:0] commit_word;
  } cdts_out_t;

  // Two BCD digits weighted as given, so bad digits give values up to 165.
  function automatic logic [7:0] bcd_dec(input logic [7:0] x);
    logic [7:0] hi;
    hi = {4'b0000, x[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0000, x[3:0]};
  endfunction

  // Binary below 100 to two BCD digits; the tens come from a reciprocal multiply.
  function automatic logic [7:0] bcd_enc(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = {8'b0, x} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = ({3'b000, tens} << 3) + ({3'b000, tens} << 1);
    ones     = x - tens_x10;
    return {tens, ones[3:0]};
  endfunction

  // Gregorian leap rule over the years the block can hold (2000 to 2165).
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // Hour modulo twelve for any five-bit hour.
  function automatic logic [4:0] mod12(input logic [4:0] h);
    logic [4:0] r;
    if (h >= 5'd24) begin
      r = h - 5'd24;
    end else if (h >= 5'd12) begin
      r = h - 5'd12;
    end else begin
      r = h;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/clock_date_time_setter.sv]
// Top level of the BCD clock date and time setting controller.
// A result word appears on out_valid in the cycle after its input word is accepted.
// One word per cycle is accepted; in_ready stays high while the result register is empty
// or is being emptied, so a stalled output only holds the input back for as long as it stalls.
// Reset (rst_n low at a clock edge): view mode, date row, 1 January 2000, weekday 3,
// 12:00 AM, twelve-hour display selected, and the result register empty.
`default_nettype none

`include "clock_date_time_setter_defines.svh"

module clock_date_time_setter
  import cdts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cdts_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cdts_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration register: the only register, decoded at addresses 0 to 3 (paddr[2] low).
  logic twelve_r;

  // Held editing state and the shown date and time.
  logic        edit_r,  edit_nxt;
  logic        row_r,   row_nxt;
  logic [1:0]  dsel_r,  dsel_nxt;
  logic [1:0]  tsel_r,  tsel_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  mon_r,   mon_nxt;
  logic [11:0] year_r,  year_nxt;
  logic [2:0]  wday_r,  wday_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic        pm_r,    pm_nxt;

  // Result register, which parts the input side from the output side.
  cdts_out_t out_r, out_nxt;
  logic      out_valid_r;

  logic in_fire;
  logic cfg_wr;

  // Decoded sample fields.
  logic [7:0]  s_min_raw, s_hr_raw, s_day_raw, s_mon_raw, s_year_raw;
  logic [5:0]  s_min;
  logic [4:0]  s_hr, s_hr12, s_day;
  logic [3:0]  s_mon;
  logic [2:0]  s_wday;
  logic [11:0] s_year;

  // Raised candidates before the clamps.
  logic [4:0]  r_day, day_mod;
  logic [3:0]  r_mon;
  logic [11:0] r_year, year_inc;
  logic [2:0]  r_wday;
  logic [4:0]  r_hour;
  logic [5:0]  hour_inc;
  logic [5:0]  r_min;
  logic [6:0]  min_inc;
  logic        r_pm;
  logic [3:0]  rc_mon;
  logic [4:0]  rc_len;

  // Commit path, worked on copies of the held values.
  logic [3:0]  c_mon;
  logic [4:0]  c_len, c_day, c_hour;
  logic [5:0]  c_min;
  logic [2:0]  c_wday;
  logic [7:0]  c_yoff;
  logic [6:0]  c_ymod;
  logic [47:0] c_word;
  logic        commit;
  logic [1:0]  tsel_step;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The configuration port never waits; a write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PaddrW-1] == 1'b0) ? {31'b0, twelve_r} : 32'b0;

  // Sample decoding: digits are weighted as they come and then saturated.
  always_comb begin
    s_min_raw  = bcd_dec({1'b0, in_data.sample_minute_bcd[6:0]});
    s_hr_raw   = bcd_dec({2'b00, in_data.sample_hour_bcd[5:0]});
    s_day_raw  = bcd_dec({2'b00, in_data.sample_date_bcd[5:0]});
    s_mon_raw  = bcd_dec({3'b000, in_data.sample_month_bcd[4:0]});
    s_year_raw = bcd_dec(in_data.sample_year_bcd);

    s_min  = (s_min_raw > 8'd59) ? 6'd59 : s_min_raw[5:0];
    s_hr   = (s_hr_raw > 8'd23) ? 5'd23 : s_hr_raw[4:0];
    if (s_day_raw == 8'd0) begin
      s_day = 5'd1;
    end else if (s_day_raw > 8'd31) begin
      s_day = 5'd31;
    end else begin
      s_day = s_day_raw[4:0];
    end
    if (s_mon_raw == 8'd0) begin
      s_mon = 4'd1;
    end else if (s_mon_raw > 8'd12) begin
      s_mon = 4'd12;
    end else begin
      s_mon = s_mon_raw[3:0];
    end
    s_wday = (in_data.sample_weekday[2:0] == 3'd0) ? 3'd3 : in_data.sample_weekday[2:0];
    s_year = YEAR_BASE + {4'b0000, s_year_raw};
    // Midnight and noon both show as twelve on the twelve-hour face.
    s_hr12 = (mod12(s_hr) == 5'd0) ? 5'd12 : mod12(s_hr);
  end

  // Commit word: hour in 24-hour form, year mod 100, other fields clamped; all encoded.
  always_comb begin
    c_mon  = (mon_r == 4'd0) ? 4'd1 : ((mon_r > 4'd12) ? 4'd12 : mon_r);
    c_len  = month_len(c_mon, year_r);
    if (day_r == 5'd0) begin
      c_day = 5'd1;
    end else if (day_r > c_len) begin
      c_day = c_len;
    end else begin
      c_day = day_r;
    end
    c_min  = (min_r > 6'd59) ? 6'd59 : min_r;
    c_wday = (wday_r == 3'd0) ? 3'd3 : wday_r;
    if (twelve_r) begin
      c_hour = mod12(hour_r) + (pm_r ? 5'd12 : 5'd0);
    end else begin
      c_hour = hour_r;
    end
    if (c_hour > 5'd23) begin
      c_hour = 5'd23;
    end
    c_yoff = 8'(year_r - YEAR_BASE);
    c_ymod = (c_yoff >= 8'd100) ? 7'(c_yoff - 8'd100) : c_yoff[6:0];
    c_word = {bcd_enc({1'b0, c_min}), bcd_enc({2'b00, c_hour}), bcd_enc({2'b00, c_day}),
              bcd_enc({3'b000, c_mon}), {5'b00000, c_wday}, bcd_enc(c_ymod)};
  end

  // Raise of the selected field, followed by the same clamps as every raise.
  always_comb begin
    r_day  = day_r;
    r_mon  = mon_r;
    r_year = year_r;
    r_wday = wday_r;
    r_hour = hour_r;
    r_min  = min_r;
    r_pm   = pm_r;

    day_mod  = (day_r >= c_len) ? day_r - c_len : day_r;
    year_inc = year_r + 12'd1;
    hour_inc = {1'b0, hour_r} + 6'd1;
    min_inc  = {1'b0, min_r} + 7'd1;

    if (!row_r) begin
      case (dsel_r)
        DSEL_DAY:   r_day  = day_mod + 5'd1;
        DSEL_MONTH: r_mon  = (mon_r >= 4'd12) ? mon_r - 4'd11 : mon_r + 4'd1;
        DSEL_YEAR:  r_year = (year_inc > YEAR_LAST) ? YEAR_BASE : year_inc;
        DSEL_WDAY:  r_wday = (wday_r >= 3'd7) ? wday_r - 3'd6 : wday_r + 3'd1;
        default:    r_day  = day_r;
      endcase
    end else begin
      case (tsel_r)
        TSEL_HOUR: begin
          if (twelve_r) begin
            r_hour = mod12(hour_r) + 5'd1;
          end else begin
            r_hour = (hour_inc >= 6'd24) ? 5'(hour_inc - 6'd24) : hour_inc[4:0];
          end
        end
        TSEL_MIN:  r_min = (min_inc >= 7'd60) ? 6'(min_inc - 7'd60) : min_inc[5:0];
        TSEL_PM:   r_pm  = twelve_r ? !pm_r : pm_r;
        default:   r_pm  = pm_r;
      endcase
    end

    rc_mon = (r_mon == 4'd0) ? 4'd1 : ((r_mon > 4'd12) ? 4'd12 : r_mon);
    rc_len = month_len(rc_mon, r_year);
  end

  // Next state and the result word for the accepted input word.
  always_comb begin
    edit_nxt = edit_r;
    row_nxt  = row_r;
    dsel_nxt = dsel_r;
    tsel_nxt = tsel_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    wday_nxt = wday_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    pm_nxt   = pm_r;
    commit   = 1'b0;
    tsel_step = tsel_r + 2'd1;

    if (!edit_r) begin
      if (in_data.action == ACT_SAMPLE) begin
        day_nxt  = s_day;
        mon_nxt  = s_mon;
        year_nxt = s_year;
        wday_nxt = s_wday;
        min_nxt  = s_min;
        if (twelve_r) begin
          hour_nxt = s_hr12;
          pm_nxt   = (s_hr >= 5'd12);
        end else begin
          hour_nxt = s_hr;
          pm_nxt   = 1'b0;
        end
      end else if (in_data.action == ACT_RAISE) begin
        edit_nxt = 1'b1;
        row_nxt  = 1'b0;
        dsel_nxt = DSEL_DAY;
        tsel_nxt = TSEL_HOUR;
      end
    end else begin
      case (in_data.action)
        ACT_RAISE: begin
          mon_nxt  = rc_mon;
          year_nxt = r_year;
          if (r_day == 5'd0) begin
            day_nxt = 5'd1;
          end else if (r_day > rc_len) begin
            day_nxt = rc_len;
          end else begin
            day_nxt = r_day;
          end
          min_nxt  = (r_min > 6'd59) ? 6'd59 : r_min;
          wday_nxt = (r_wday == 3'd0) ? 3'd3 : r_wday;
          if (twelve_r) begin
            hour_nxt = (r_hour == 5'd0 || r_hour > 5'd12) ? 5'd12 : r_hour;
          end else begin
            hour_nxt = (r_hour > 5'd23) ? 5'd23 : r_hour;
          end
          pm_nxt = r_pm;
        end
        ACT_NEXT: begin
          if (row_r) begin
            // The AM/PM field is skipped on the 24-hour face.
            if ((!twelve_r && tsel_step == TSEL_PM) || tsel_r >= TSEL_PM) begin
              tsel_nxt = TSEL_HOUR;
            end else begin
              tsel_nxt = tsel_step;
            end
          end else begin
            dsel_nxt = dsel_r + 2'd1;
          end
        end
        ACT_SWAP: begin
          row_nxt = !row_r;
          if (!row_r) begin
            tsel_nxt = TSEL_HOUR;
          end else begin
            dsel_nxt = DSEL_DAY;
          end
        end
        ACT_COMMIT: begin
          commit   = 1'b1;
          edit_nxt = 1'b0;
        end
        default: begin
          commit = 1'b0;
        end
      endcase
    end

    out_nxt.editing = edit_nxt;
    if (!edit_nxt) begin
      out_nxt.cursor_field = 3'd0;
    end else if (row_nxt) begin
      out_nxt.cursor_field = {1'b1, tsel_nxt};
    end else begin
      out_nxt.cursor_field = {1'b0, dsel_nxt};
    end
    out_nxt.shown_day     = day_nxt;
    out_nxt.shown_month   = mon_nxt;
    out_nxt.shown_year    = year_nxt;
    out_nxt.shown_weekday = wday_nxt;
    out_nxt.shown_hour    = hour_nxt;
    out_nxt.shown_minute  = min_nxt;
    out_nxt.shown_pm      = pm_nxt;
    out_nxt.commit_valid  = commit;
    out_nxt.commit_word   = commit ? c_word : 48'd0;
  end

  // Control state and the configuration register are reset; the result payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twelve_r    <= 1'b1;
      edit_r      <= 1'b0;
      row_r       <= 1'b0;
      dsel_r      <= DSEL_DAY;
      tsel_r      <= TSEL_HOUR;
      day_r       <= 5'd1;
      mon_r       <= 4'd1;
      year_r      <= YEAR_BASE;
      wday_r      <= 3'd3;
      hour_r      <= 5'd12;
      min_r       <= 6'd0;
      pm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[PaddrW-1] == 1'b0) begin
        twelve_r <= pwdata[0];
      end
      if (in_fire) begin
        edit_r      <= edit_nxt;
        row_r       <= row_nxt;
        dsel_r      <= dsel_nxt;
        tsel_r      <= tsel_nxt;
        day_r       <= day_nxt;
        mon_r       <= mon_nxt;
        year_r      <= year_nxt;
        wday_r      <= wday_nxt;
        hour_r      <= hour_nxt;
        min_r       <= min_nxt;
        pm_r        <= pm_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // A commit always leaves edit mode in the same word.
  `CDTS_ASSERT_IMP(a_commit_leaves_edit, out_valid && out_data.commit_valid,
                   !out_data.editing)
  // In view mode the cursor reads as the day field.
  `CDTS_ASSERT_IMP(a_view_cursor_zero, out_valid && !out_data.editing,
                   out_data.cursor_field == 3'd0)
  // An accepted commit in edit mode yields a commit word in the next cycle.
  `CDTS_ASSERT_NXT(a_commit_reported,
                   in_fire && edit_r && in_data.action == ACT_COMMIT,
                   out_valid && out_data.commit_valid)
  // The held month never leaves its calendar range.
  `CDTS_ASSERT_IMP(a_month_range, out_valid,
                   out_data.shown_month >= 4'd1 && out_data.shown_month <= 4'd12)

endmodule

`default_nettype wire
